FILE: rtl/jits_pkg.sv
// Shared types and constants for the joint impedance torque step block.
`default_nettype none

package jits_pkg;

    // Default number of joints served by one block
    localparam int JOINTS_DEFAULT = 7;

    // Configuration port
    localparam int PADDR_W = 3;
    localparam int PDATA_W = 32;
    localparam logic [0:0] REG_MAX_TORQUE_STEP = 1'b0;
    localparam logic [30:0] MAX_TORQUE_STEP_RESET = 31'd65536;

    // Operation codes carried by a request
    typedef enum logic [1:0] {
        OP_LOAD  = 2'd0,
        OP_START = 2'd1,
        OP_STEP  = 2'd2
    } op_t;

    // Sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ADV,
        ST_ERR,
        ST_DES,
        ST_MUL,
        ST_TRQ,
        ST_DONE
    } fsm_state_t;

    // One joint's stored state, one memory entry
    typedef struct packed {
        logic signed [31:0] desired_position;
        logic signed [31:0] filtered_velocity;
        logic [31:0]        stiffness;
        logic [31:0]        damping;
        logic [30:0]        position_error_limit;
    } joint_state_t;

endpackage

`default_nettype wire

FILE: rtl/joint_impedance_torque_step_core.sv
// Per-joint impedance controller with torque rate limit, top level.
//
// Requests arrive on req_valid/req_stall; each names a joint and an operation
// (load gains and error limit, start the joint, or run one control step).
// Every accepted request yields exactly one result on rsp_valid/rsp_stall.
// Joint state lives in one synchronous memory, one entry per joint, read on
// accept and written back when the result is produced; requests are worked
// one at a time, so no two accesses to an entry overlap.
// A load, a start or a request for a joint out of range passes through
// ST_ADV and ST_DONE only; a control step also runs the chain of memory
// read, position clamp, damping and stiffness multiplies and the torque
// rate clamp. The result is valid in the cycle after the last of these.
// The result sits in an output register, so a stalled receiver holds only
// the finished result; the next request is accepted and worked, and it
// waits in ST_DONE until the output register is taken.
// Reset clears all joint state to zero at once (per-entry valid bits),
// sets max_torque_step to 1.0 Nm and empties the output register.
// max_torque_step is written through the APB-style port at byte address 0.
`default_nettype none

module joint_impedance_torque_step_core #(
    parameter int JOINTS = jits_pkg::JOINTS_DEFAULT
) (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    // request channel
    input  wire logic                         req_valid,
    output logic                              req_stall,
    input  wire logic [1:0]                   operation,
    input  wire logic [2:0]                   joint,
    input  wire logic signed [31:0]           measured_position,
    input  wire logic signed [31:0]           measured_velocity,
    input  wire logic signed [31:0]           last_torque,
    input  wire logic signed [31:0]           velocity_demand,
    input  wire logic [19:0]                  period,
    input  wire logic [31:0]                  stiffness_value,
    input  wire logic [31:0]                  damping_value,
    input  wire logic [30:0]                  error_limit_value,
    // result channel
    output logic                              rsp_valid,
    input  wire logic                         rsp_stall,
    output logic [2:0]                        joint_echo,
    output logic signed [31:0]                torque_demand,
    output logic                              position_clamped,
    output logic                              torque_limited,
    // configuration port
    input  wire logic                         psel,
    input  wire logic                         penable,
    input  wire logic                         pwrite,
    input  wire logic [jits_pkg::PADDR_W-1:0] paddr,
    input  wire logic [jits_pkg::PDATA_W-1:0] pwdata,
    output logic [jits_pkg::PDATA_W-1:0]      prdata,
    output logic                              pready
);

    localparam int JW = (JOINTS > 1) ? $clog2(JOINTS) : 1;

    localparam logic signed [32:0] S33_MAX = 33'sh07FFFFFFF;
    localparam logic signed [32:0] S33_MIN = -33'sh080000000;
    localparam logic signed [45:0] S46_MAX = 46'sh0000_7FFF_FFFF;
    localparam logic signed [45:0] S46_MIN = -46'sh0000_8000_0000;

    // ---------------------------------------------------------------------
    // Configuration register
    // ---------------------------------------------------------------------
    logic [30:0] max_step_reg;
    logic        cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready &&
                    (paddr[2] == jits_pkg::REG_MAX_TORQUE_STEP);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_step_reg <= jits_pkg::MAX_TORQUE_STEP_RESET;
        end
        else if (cfg_wr)
        begin
            max_step_reg <= pwdata[30:0];
        end
    end

    // Return the register on reads, zero elsewhere
    always_comb
    begin
        if (paddr[2] == jits_pkg::REG_MAX_TORQUE_STEP)
        begin
            prdata = {1'b0, max_step_reg};
        end
        else
        begin
            prdata = '0;
        end
    end

    // ---------------------------------------------------------------------
    // Sequencer
    // ---------------------------------------------------------------------
    jits_pkg::fsm_state_t state_reg, state_next;

    logic [4:0]    joint_ext;
    logic          req_hit;
    logic [JW-1:0] rd_addr;
    logic          req_take;
    logic          rd_en;
    logic          rsp_load;
    logic          wr_en;
    logic          rsp_valid_reg;

    // request captured at accept
    logic [1:0]         op_reg;
    logic [2:0]         joint_reg;
    logic [JW-1:0]      addr_reg;
    logic               hit_reg;
    logic signed [31:0] q_reg;
    logic signed [31:0] dq_reg;
    logic signed [31:0] last_reg;
    logic [31:0]        stiff_in_reg;
    logic [31:0]        damp_in_reg;
    logic [30:0]        lim_in_reg;
    logic signed [52:0] vp_reg;

    assign joint_ext = {2'b00, joint};
    assign req_hit   = joint_ext < 5'(JOINTS);
    assign rd_addr   = joint_ext[JW-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= jits_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            jits_pkg::ST_IDLE:
            begin
                if (req_valid)
                begin
                    state_next = jits_pkg::ST_ADV;
                end
            end
            jits_pkg::ST_ADV:
            begin
                if (hit_reg && (op_reg == jits_pkg::OP_STEP))
                begin
                    state_next = jits_pkg::ST_ERR;
                end
                else
                begin
                    state_next = jits_pkg::ST_DONE;
                end
            end
            jits_pkg::ST_ERR: state_next = jits_pkg::ST_DES;
            jits_pkg::ST_DES: state_next = jits_pkg::ST_MUL;
            jits_pkg::ST_MUL: state_next = jits_pkg::ST_TRQ;
            jits_pkg::ST_TRQ: state_next = jits_pkg::ST_DONE;
            jits_pkg::ST_DONE:
            begin
                if (!(rsp_valid_reg && rsp_stall))
                begin
                    state_next = jits_pkg::ST_IDLE;
                end
            end
            default: state_next = jits_pkg::ST_IDLE;
        endcase
    end

    // Control outputs
    always_comb
    begin
        req_stall = 1'b1;
        rsp_load  = 1'b0;
        wr_en     = 1'b0;
        case (state_reg)
            jits_pkg::ST_IDLE:
            begin
                req_stall = 1'b0;
            end
            jits_pkg::ST_DONE:
            begin
                rsp_load = !(rsp_valid_reg && rsp_stall);
                wr_en    = rsp_load && hit_reg &&
                           (op_reg inside {jits_pkg::OP_LOAD, jits_pkg::OP_START,
                                           jits_pkg::OP_STEP});
            end
            default:
            begin
                req_stall = 1'b1;
            end
        endcase
    end

    assign req_take = req_valid && !req_stall;
    assign rd_en    = req_take && req_hit;

    // Capture the request
    always_ff @(posedge clk)
    begin
        if (req_take)
        begin
            op_reg       <= operation;
            joint_reg    <= joint;
            addr_reg     <= rd_addr;
            hit_reg      <= req_hit;
            q_reg        <= measured_position;
            dq_reg       <= measured_velocity;
            last_reg     <= last_torque;
            stiff_in_reg <= stiffness_value;
            damp_in_reg  <= damping_value;
            lim_in_reg   <= error_limit_value;
            vp_reg       <= 53'(velocity_demand) * 53'($signed({1'b0, period}));
        end
    end

    // ---------------------------------------------------------------------
    // Joint state memory
    // ---------------------------------------------------------------------
    jits_pkg::joint_state_t mem [JOINTS];
    jits_pkg::joint_state_t rd_data_reg;
    jits_pkg::joint_state_t entry_q;
    jits_pkg::joint_state_t wr_data;
    logic [JOINTS-1:0]      valid_reg;
    logic                   rd_valid_reg;

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
        if (wr_en)
        begin
            mem[addr_reg] <= wr_data;
        end
    end

    // Mark entries written since reset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg    <= '0;
            rd_valid_reg <= 1'b0;
        end
        else
        begin
            if (rd_en)
            begin
                rd_valid_reg <= valid_reg[rd_addr];
            end
            if (wr_en)
            begin
                valid_reg[addr_reg] <= 1'b1;
            end
        end
    end

    // An entry never written reads as zero
    assign entry_q = rd_valid_reg ? rd_data_reg : '0;

    // ---------------------------------------------------------------------
    // Control step datapath
    // ---------------------------------------------------------------------
    logic signed [31:0] fv_reg,    fv_next;
    logic signed [33:0] adv_reg,   adv_next;
    logic signed [31:0] ec_reg,    ec_next;
    logic signed [63:0] dprod_reg, dprod_next;
    logic signed [31:0] des_reg,   des_next;
    logic signed [31:0] err_reg,   err_next;
    logic               pclamp_reg, pclamp_next;
    logic signed [63:0] pprod_reg, pprod_next;
    logic signed [45:0] diff_reg,  diff_next;

    logic signed [32:0] fv_sum;
    logic signed [34:0] pos_err;
    logic signed [34:0] lim_s;
    logic signed [32:0] des_sum;
    logic signed [32:0] err_wide;

    // Filter velocity and advance the desired position
    always_comb
    begin
        fv_sum   = 33'(entry_q.filtered_velocity) + 33'(dq_reg);
        fv_next  = 32'(fv_sum >>> 1);
        adv_next = 34'(entry_q.desired_position) + 34'(vp_reg >>> 20);
    end

    // Clamp the position error to the joint's limit; damping product
    always_comb
    begin
        pos_err = 35'(adv_reg) - 35'(q_reg);
        lim_s   = 35'($signed({1'b0, entry_q.position_error_limit}));
        if (pos_err > lim_s)
        begin
            ec_next = 32'(lim_s);
        end
        else if (pos_err < -lim_s)
        begin
            ec_next = 32'(-lim_s);
        end
        else
        begin
            ec_next = 32'(pos_err);
        end
        dprod_next = 64'($signed({1'b0, entry_q.damping})) * 64'(fv_reg);
    end

    // Saturate the new desired position and recompute the error
    always_comb
    begin
        des_sum = 33'(q_reg) + 33'(ec_reg);
        if (des_sum > S33_MAX)
        begin
            des_next = 32'(S33_MAX);
        end
        else if (des_sum < S33_MIN)
        begin
            des_next = 32'(S33_MIN);
        end
        else
        begin
            des_next = 32'(des_sum);
        end
        err_wide    = 33'(des_next) - 33'(q_reg);
        err_next    = 32'(err_wide);
        pclamp_next = 34'(des_next) != adv_reg;
    end

    // Stiffness product, then torque change against the last command
    always_comb
    begin
        pprod_next = 64'($signed({1'b0, entry_q.stiffness})) * 64'(err_reg);
        diff_next  = 46'((pprod_reg >>> 20) - (dprod_reg >>> 20) - 64'(last_reg));
    end

    always_ff @(posedge clk)
    begin
        fv_reg     <= fv_next;
        adv_reg    <= adv_next;
        ec_reg     <= ec_next;
        dprod_reg  <= dprod_next;
        des_reg    <= des_next;
        err_reg    <= err_next;
        pclamp_reg <= pclamp_next;
        pprod_reg  <= pprod_next;
        diff_reg   <= diff_next;
    end

    // Rate limit and saturate the torque command
    logic signed [45:0] step_s;
    logic signed [45:0] cdiff;
    logic signed [45:0] cmd_wide;
    logic signed [31:0] cmd;
    logic               tlim;

    always_comb
    begin
        step_s = 46'($signed({1'b0, max_step_reg}));
        if (diff_reg > step_s)
        begin
            cdiff = step_s;
        end
        else if (diff_reg < -step_s)
        begin
            cdiff = -step_s;
        end
        else
        begin
            cdiff = diff_reg;
        end
        cmd_wide = 46'(last_reg) + cdiff;
        tlim     = cdiff != diff_reg;
        if (cmd_wide > S46_MAX)
        begin
            cmd  = 32'(S46_MAX);
            tlim = 1'b1;
        end
        else if (cmd_wide < S46_MIN)
        begin
            cmd  = 32'(S46_MIN);
            tlim = 1'b1;
        end
        else
        begin
            cmd = 32'(cmd_wide);
        end
    end

    // Write-back data for the addressed joint
    always_comb
    begin
        wr_data = entry_q;
        case (op_reg)
            jits_pkg::OP_LOAD:
            begin
                wr_data.stiffness            = stiff_in_reg;
                wr_data.damping              = damp_in_reg;
                wr_data.position_error_limit = lim_in_reg;
            end
            jits_pkg::OP_START:
            begin
                wr_data.desired_position  = q_reg;
                wr_data.filtered_velocity = '0;
            end
            jits_pkg::OP_STEP:
            begin
                wr_data.desired_position  = des_reg;
                wr_data.filtered_velocity = fv_reg;
            end
            default:
            begin
                wr_data = entry_q;
            end
        endcase
    end

    // ---------------------------------------------------------------------
    // Output register
    // ---------------------------------------------------------------------
    logic step_ok;

    assign step_ok = hit_reg && (op_reg == jits_pkg::OP_STEP);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_valid_reg <= 1'b0;
        end
        else if (rsp_load)
        begin
            rsp_valid_reg <= 1'b1;
        end
        else if (!rsp_stall)
        begin
            rsp_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rsp_load)
        begin
            joint_echo       <= joint_reg;
            torque_demand    <= step_ok ? cmd : '0;
            position_clamped <= step_ok && pclamp_reg;
            torque_limited   <= step_ok && tlim;
        end
    end

    assign rsp_valid = rsp_valid_reg;

endmodule

`default_nettype wire

FILE: rtl/jits_checker.sv
// Port-level checks for the joint impedance torque step block, with bind.
`default_nettype none

module jits_checker (
    input wire logic               clk,
    input wire logic               rst_n,
    input wire logic               req_valid,
    input wire logic               req_stall,
    input wire logic               rsp_valid,
    input wire logic               rsp_stall,
    input wire logic [2:0]         joint_echo,
    input wire logic signed [31:0] torque_demand,
    input wire logic               position_clamped,
    input wire logic               torque_limited
);

    // Hold a stalled result
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_stall |=> rsp_valid)
        else $error("result dropped while stalled");

    a_rsp_stable: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_stall |=> $stable(torque_demand) && $stable(joint_echo) &&
            $stable(position_clamped) && $stable(torque_limited))
        else $error("stalled result changed");

    // Work one request at a time
    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && !req_stall |=> req_stall)
        else $error("request taken while another is in work");

    // A result appears only from a request in work
    a_rsp_from_work: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rsp_valid) |-> $past(req_stall))
        else $error("result without a request in work");

    a_no_instant_rsp: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && !req_stall |=> !$rose(rsp_valid))
        else $error("result too soon after request");

endmodule

bind joint_impedance_torque_step_core jits_checker u_jits_checker (.*);

`default_nettype wire

FILE: tb/joint_impedance_torque_step_core_tb.sv
// Self-checking testbench for the joint impedance torque step core.
`timescale 1ns / 1ps

module joint_impedance_torque_step_core_tb;

    localparam int JOINTS = jits_pkg::JOINTS_DEFAULT;
    localparam int CYCLE_LIMIT = 200000;
    localparam int MAX_PRINTED = 200;
    localparam logic [1:0] OP_UNUSED = 2'd3;
    localparam logic [jits_pkg::PADDR_W-1:0] STEP_LIMIT_ADDR =
        jits_pkg::PADDR_W'({jits_pkg::REG_MAX_TORQUE_STEP, 2'b00});
    localparam longint S32_MAX = 64'sd2147483647;
    localparam longint S32_MIN = -64'sd2147483648;
    localparam logic [19:0] PERIOD_1MS = 20'd1049;

    typedef struct {
        logic [1:0]         op;
        logic [2:0]         joint;
        logic signed [31:0] mpos;
        logic signed [31:0] mvel;
        logic signed [31:0] last_trq;
        logic signed [31:0] vel_cmd;
        logic [19:0]        period;
        logic [31:0]        stiff;
        logic [31:0]        damp;
        logic [30:0]        elim;
    } joint_request_t;

    typedef struct {
        logic [2:0]         joint;
        logic signed [31:0] torque;
        logic               pclamp;
        logic               tlim;
    } torque_result_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    logic               req_valid = 1'b0;
    logic               req_stall;
    logic [1:0]         operation = '0;
    logic [2:0]         joint = '0;
    logic signed [31:0] measured_position = '0;
    logic signed [31:0] measured_velocity = '0;
    logic signed [31:0] last_torque = '0;
    logic signed [31:0] velocity_demand = '0;
    logic [19:0]        period = '0;
    logic [31:0]        stiffness_value = '0;
    logic [31:0]        damping_value = '0;
    logic [30:0]        error_limit_value = '0;

    logic               rsp_valid;
    logic               rsp_stall = 1'b0;
    logic [2:0]         joint_echo;
    logic signed [31:0] torque_demand;
    logic               position_clamped;
    logic               torque_limited;

    logic                         psel = 1'b0;
    logic                         penable = 1'b0;
    logic                         pwrite = 1'b0;
    logic [jits_pkg::PADDR_W-1:0] paddr = '0;
    logic [jits_pkg::PDATA_W-1:0] pwdata = '0;
    logic [jits_pkg::PDATA_W-1:0] prdata;
    logic                         pready;

    // Predicted per-joint state and the torque step limit
    logic signed [31:0] des_pos  [JOINTS];
    logic signed [31:0] filt_vel [JOINTS];
    logic [31:0]        kp       [JOINTS];
    logic [31:0]        kd       [JOINTS];
    logic [30:0]        err_limit[JOINTS];
    logic [30:0]        step_limit;

    joint_request_t pending_requests[$];
    torque_result_t expected_torques[$];

    int  mismatches = 0;
    int  cycle_count = 0;
    int  req_gap = 0;
    int  rsp_wait = 0;
    int  hold_left = 0;
    bit  sender_idle_on = 1'b0;
    bit  receiver_idle_on = 1'b0;
    bit  req_fired = 1'b0;
    bit  rsp_fired = 1'b0;

    joint_impedance_torque_step_core #(.JOINTS(JOINTS)) u_dut (
        .clk(clk),
        .rst_n(rst_n),
        .req_valid(req_valid),
        .req_stall(req_stall),
        .operation(operation),
        .joint(joint),
        .measured_position(measured_position),
        .measured_velocity(measured_velocity),
        .last_torque(last_torque),
        .velocity_demand(velocity_demand),
        .period(period),
        .stiffness_value(stiffness_value),
        .damping_value(damping_value),
        .error_limit_value(error_limit_value),
        .rsp_valid(rsp_valid),
        .rsp_stall(rsp_stall),
        .joint_echo(joint_echo),
        .torque_demand(torque_demand),
        .position_clamped(position_clamped),
        .torque_limited(torque_limited),
        .psel(psel),
        .penable(penable),
        .pwrite(pwrite),
        .paddr(paddr),
        .pwdata(pwdata),
        .prdata(prdata),
        .pready(pready)
    );

    always #2 clk = ~clk;

    task automatic report_mismatch(input string msg);
        if (mismatches < MAX_PRINTED)
            $display("MISMATCH at %0t: %s", $time, msg);
        mismatches++;
    endtask

    function automatic longint clamp_long(input longint x, input longint lo, input longint hi);
        if (x < lo)
            return lo;
        if (x > hi)
            return hi;
        return x;
    endfunction

    // Apply one request to the predicted joint state and return the torque it yields
    function automatic torque_result_t compute_torque_step(input joint_request_t r);
        torque_result_t res;
        longint q, fv, adv, err, des, lim, trq, diff, cdiff;
        res.joint = r.joint;
        res.torque = '0;
        res.pclamp = 1'b0;
        res.tlim = 1'b0;
        if (r.joint < JOINTS)
        begin
            case (r.op)
                jits_pkg::OP_LOAD:
                begin
                    kp[r.joint] = r.stiff;
                    kd[r.joint] = r.damp;
                    err_limit[r.joint] = r.elim;
                end
                jits_pkg::OP_START:
                begin
                    des_pos[r.joint] = r.mpos;
                    filt_vel[r.joint] = '0;
                end
                jits_pkg::OP_STEP:
                begin
                    q = longint'(r.mpos);
                    // halve the filtered velocity toward the measurement
                    fv = (longint'(filt_vel[r.joint]) + longint'(r.mvel)) >>> 1;
                    filt_vel[r.joint] = fv[31:0];
                    // advance the setpoint, then clamp it around the measurement
                    adv = longint'(des_pos[r.joint])
                        + ((longint'(r.vel_cmd) * longint'(r.period)) >>> 20);
                    lim = longint'(err_limit[r.joint]);
                    err = clamp_long(adv - q, -lim, lim);
                    des = clamp_long(q + err, S32_MIN, S32_MAX);
                    res.pclamp = (des != adv);
                    des_pos[r.joint] = des[31:0];
                    err = des - q;
                    // spring minus damper, then rate limit and saturate
                    trq = ((longint'(kp[r.joint]) * err) >>> 20)
                        - ((longint'(kd[r.joint]) * fv) >>> 20);
                    diff = trq - longint'(r.last_trq);
                    cdiff = clamp_long(diff, -longint'(step_limit), longint'(step_limit));
                    res.tlim = (cdiff != diff);
                    trq = longint'(r.last_trq) + cdiff;
                    if (trq > S32_MAX || trq < S32_MIN)
                    begin
                        trq = clamp_long(trq, S32_MIN, S32_MAX);
                        res.tlim = 1'b1;
                    end
                    res.torque = trq[31:0];
                end
                default:
                begin
                end
            endcase
        end
        return res;
    endfunction

    // Count cycles, check results and predict each accepted request
    always @(posedge clk)
    begin
        joint_request_t r;
        torque_result_t exp_res;
        cycle_count = cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", cycle_count);
            $display("RESULT: ERROR");
            $finish;
        end
        else
        begin
            req_fired <= rst_n && req_valid && !req_stall;
            rsp_fired <= rst_n && rsp_valid && !rsp_stall;
            if (rst_n && rsp_valid && !rsp_stall)
            begin
                if (expected_torques.size() == 0)
                begin
                    report_mismatch($sformatf("result for joint %0d with none expected",
                                              joint_echo));
                end
                else
                begin
                    exp_res = expected_torques.pop_front();
                    if (joint_echo !== exp_res.joint)
                        report_mismatch($sformatf("joint_echo %0d, want %0d",
                                                  joint_echo, exp_res.joint));
                    if (torque_demand !== exp_res.torque)
                        report_mismatch($sformatf("joint %0d torque_demand %0d, want %0d",
                                                  exp_res.joint, torque_demand,
                                                  exp_res.torque));
                    if (position_clamped !== exp_res.pclamp)
                        report_mismatch($sformatf("joint %0d position_clamped %b, want %b",
                                                  exp_res.joint, position_clamped,
                                                  exp_res.pclamp));
                    if (torque_limited !== exp_res.tlim)
                        report_mismatch($sformatf("joint %0d torque_limited %b, want %b",
                                                  exp_res.joint, torque_limited,
                                                  exp_res.tlim));
                end
            end
            if (rst_n && req_valid && !req_stall)
            begin
                r.op = operation;
                r.joint = joint;
                r.mpos = measured_position;
                r.mvel = measured_velocity;
                r.last_trq = last_torque;
                r.vel_cmd = velocity_demand;
                r.period = period;
                r.stiff = stiffness_value;
                r.damp = damping_value;
                r.elim = error_limit_value;
                exp_res = compute_torque_step(r);
                expected_torques = {expected_torques, exp_res};
            end
        end
    end

    // Offer pending requests, with a random gap after each one when sender idling is on
    always @(negedge clk)
    begin
        joint_request_t r;
        if (rst_n && (!req_valid || req_fired))
        begin
            if (req_gap > 0)
            begin
                req_valid <= 1'b0;
                req_gap <= req_gap - 1;
            end
            else if (pending_requests.size() > 0)
            begin
                r = pending_requests.pop_front();
                operation <= r.op;
                joint <= r.joint;
                measured_position <= r.mpos;
                measured_velocity <= r.mvel;
                last_torque <= r.last_trq;
                velocity_demand <= r.vel_cmd;
                period <= r.period;
                stiffness_value <= r.stiff;
                damping_value <= r.damp;
                error_limit_value <= r.elim;
                req_valid <= 1'b1;
                req_gap <= sender_idle_on ? $urandom_range(0, 4) : 0;
            end
            else
            begin
                req_valid <= 1'b0;
            end
        end
    end

    // Stall results for a random wait after each one taken when receiver idling is on, or for a long hold-off
    always @(negedge clk)
    begin
        int w;
        w = rsp_wait;
        if (rsp_fired)
            w = receiver_idle_on ? $urandom_range(0, 4) : 0;
        if (hold_left > 0)
        begin
            rsp_stall <= 1'b1;
        end
        else if (w > 0)
        begin
            rsp_stall <= 1'b1;
            w = w - 1;
        end
        else
        begin
            rsp_stall <= 1'b0;
        end
        rsp_wait <= w;
    end

    // Count down the long receiver hold-off
    always @(posedge clk)
    begin
        if (hold_left > 0)
            hold_left <= hold_left - 1;
    end

    task automatic add_request(input logic [1:0] op, input logic [2:0] jnt,
                               input logic [31:0] mpos, input logic [31:0] mvel,
                               input logic [31:0] last_trq, input logic [31:0] vel_cmd,
                               input logic [19:0] per, input logic [31:0] stiff,
                               input logic [31:0] damp, input logic [30:0] elim);
        joint_request_t r;
        r.op = op;
        r.joint = jnt;
        r.mpos = mpos;
        r.mvel = mvel;
        r.last_trq = last_trq;
        r.vel_cmd = vel_cmd;
        r.period = per;
        r.stiff = stiff;
        r.damp = damp;
        r.elim = elim;
        pending_requests = {pending_requests, r};
    endtask

    // Signed value of about the given magnitude, with full-range and extreme picks
    function automatic logic [31:0] signed_value(input int bits);
        logic signed [31:0] v;
        v = $urandom;
        case ($urandom_range(0, 19))
            0, 1:
                return v;
            2:
                case ($urandom_range(0, 4))
                    0: return 32'h0000_0000;
                    1: return 32'hFFFF_FFFF;
                    2: return 32'h8000_0000;
                    3: return 32'h7FFF_FFFF;
                    default: return 32'h0000_0001;
                endcase
            default:
                return v >>> (32 - bits);
        endcase
    endfunction

    function automatic logic [31:0] gain_value();
        case ($urandom_range(0, 9))
            0, 1: return $urandom;
            2: return $urandom_range(0, 1) ? 32'hFFFF_FFFF : 32'h0;
            default: return $urandom >> (32 - $urandom_range(8, 22));
        endcase
    endfunction

    function automatic logic [30:0] limit_value();
        logic [31:0] v;
        v = $urandom;
        case ($urandom_range(0, 19))
            0, 1, 2: return '0;
            3, 4: return 31'h7FFF_FFFF;
            5, 6, 7: return v[30:0];
            default: return 31'(v >> (32 - $urandom_range(10, 24)));
        endcase
    endfunction

    function automatic logic [19:0] period_value();
        case ($urandom_range(0, 19))
            0, 1: return 20'h0;
            2, 3: return 20'hFFFFF;
            4, 5, 6, 7: return 20'($urandom_range(0, 20'hFFFFF));
            8, 9, 10: return 20'($urandom_range(0, 4096));
            default: return PERIOD_1MS;
        endcase
    endfunction

    // Mostly load / start / step sequences per joint, the rest noise
    task automatic add_random_traffic(input int count);
        int added;
        logic [2:0] jnt;
        logic signed [31:0] base;
        added = 0;
        while (added < count)
        begin
            if ($urandom_range(0, 99) < 85)
            begin
                jnt = 3'($urandom_range(0, JOINTS - 1));
                base = signed_value(24);
                if ($urandom_range(0, 3) != 0)
                begin
                    add_request(jits_pkg::OP_LOAD, jnt, $urandom, $urandom, $urandom,
                                $urandom, 20'($urandom), gain_value(), gain_value(),
                                limit_value());
                    added++;
                end
                if ($urandom_range(0, 4) != 0)
                begin
                    add_request(jits_pkg::OP_START, jnt, base, $urandom, $urandom, $urandom,
                                20'($urandom), $urandom, $urandom, 31'($urandom));
                    added++;
                end
                repeat ($urandom_range(1, 10))
                begin
                    add_request(jits_pkg::OP_STEP, jnt, base + signed_value(18),
                                signed_value(22), signed_value(22), signed_value(22),
                                period_value(), $urandom, $urandom, 31'($urandom));
                    added++;
                end
            end
            else
            begin
                add_request(2'($urandom_range(0, 3)), 3'($urandom_range(0, 7)), $urandom,
                            $urandom, $urandom, $urandom, 20'($urandom), $urandom,
                            $urandom, 31'($urandom));
                added++;
            end
        end
    endtask

    // Hold until every request has been offered and every result has come back
    task automatic wait_until_idle();
        while (pending_requests.size() != 0 || req_valid || expected_torques.size() != 0)
            @(posedge clk);
    endtask

    task automatic write_step_limit(input logic [31:0] value);
        @(negedge clk);
        psel = 1'b1;
        penable = 1'b0;
        pwrite = 1'b1;
        paddr = STEP_LIMIT_ADDR;
        pwdata = value;
        @(negedge clk);
        penable = 1'b1;
        @(posedge clk);
        step_limit = value[30:0];
        @(negedge clk);
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
    endtask

    task automatic read_step_limit();
        @(negedge clk);
        psel = 1'b1;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = STEP_LIMIT_ADDR;
        @(negedge clk);
        penable = 1'b1;
        @(posedge clk);
        if (prdata !== {1'b0, step_limit})
            report_mismatch($sformatf("max_torque_step reads %0h, want %0h",
                                      prdata, {1'b0, step_limit}));
        @(negedge clk);
        psel = 1'b0;
        penable = 1'b0;
    endtask

    initial
    begin
        logic [31:0] limit_settings[6];
        for (int i = 0; i < JOINTS; i++)
        begin
            des_pos[i] = '0;
            filt_vel[i] = '0;
            kp[i] = '0;
            kd[i] = '0;
            err_limit[i] = '0;
        end
        step_limit = jits_pkg::MAX_TORQUE_STEP_RESET;
        limit_settings = '{32'h0000_0000, 32'hFFFF_FFFF, 32'h0000_0001,
                           $urandom, 32'h0004_0000, 32'h8000_0100};

        // Hold reset, then release it away from the clock edge
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        read_step_limit();

        // Directed: reset values, out-of-range joint, unused code, field extremes
        add_request(jits_pkg::OP_STEP, 0, 32'h0010_0000, 32'h0020_0000, 32'h0001_0000,
                    32'h0010_0000, PERIOD_1MS, 0, 0, 0);
        add_request(OP_UNUSED, 2, 32'h1234_5678, 32'h1, 32'h1, 32'h1, 20'h1,
                    32'h1, 32'h1, 31'h1);
        add_request(jits_pkg::OP_LOAD, 7, 0, 0, 0, 0, 0, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                    31'h7FFF_FFFF);
        add_request(jits_pkg::OP_STEP, 7, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF,
                    32'h7FFF_FFFF, 20'hFFFFF, 0, 0, 0);
        add_request(jits_pkg::OP_START, 7, 32'h8000_0000, 0, 0, 0, 0, 0, 0, 0);
        add_request(jits_pkg::OP_LOAD, 1, 0, 0, 0, 0, 0, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                    31'h7FFF_FFFF);
        add_request(jits_pkg::OP_START, 1, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 0, 0, 0, 0, 0, 0);
        add_request(jits_pkg::OP_STEP, 1, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF,
                    32'h7FFF_FFFF, 20'hFFFFF, 0, 0, 0);
        add_request(jits_pkg::OP_STEP, 1, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                    32'h8000_0000, 20'hFFFFF, 0, 0, 0);
        add_request(jits_pkg::OP_LOAD, 3, 0, 0, 0, 0, 0, 32'h0001_0000, 32'h0,
                    31'h0010_0000);
        add_request(jits_pkg::OP_START, 3, 32'h0, 0, 0, 0, 0, 0, 0, 0);
        add_request(jits_pkg::OP_STEP, 3, 32'h0, 32'h0, 32'h0, 32'h0010_0000, 20'hFFFFF,
                    0, 0, 0);
        add_request(jits_pkg::OP_STEP, 3, 32'h0, 32'h0, 32'h0, 32'h7FFF_FFFF, 20'h0_8000,
                    0, 0, 0);
        add_request(jits_pkg::OP_STEP, 3, 32'h0, 32'h0, 32'h0, 32'h8000_0000, 20'hFFFFF,
                    0, 0, 0);
        add_request(jits_pkg::OP_STEP, 3, 32'h0, 32'h0, 32'h0, 32'h0, 20'h0, 0, 0, 0);
        add_request(jits_pkg::OP_LOAD, 4, 0, 0, 0, 0, 0, 32'h0, 32'h0001_0000, 31'h0);
        add_request(jits_pkg::OP_START, 4, 32'h8000_0000, 0, 0, 0, 0, 0, 0, 0);
        add_request(jits_pkg::OP_STEP, 4, 32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                    32'h7FFF_FFFF, 20'hFFFFF, 0, 0, 0);
        add_request(jits_pkg::OP_LOAD, 6, 0, 0, 0, 0, 0, 32'h0004_0000, 32'h0000_8000,
                    31'h0001_0000);
        add_request(jits_pkg::OP_START, 6, 32'hFFF0_0000, 0, 0, 0, 0, 0, 0, 0);
        add_request(jits_pkg::OP_STEP, 6, 32'hFFF0_0100, 32'hFFFF_F000, 32'h0000_0100,
                    32'hFFF8_0000, PERIOD_1MS, 0, 0, 0);
        add_request(jits_pkg::OP_STEP, 5, 32'h0, 32'h7FFF_FFFF, 32'h0, 32'h0, PERIOD_1MS,
                    0, 0, 0);
        wait_until_idle();

        // Random phases, each under its own torque step limit and idling mix
        for (int k = 0; k < 6; k++)
        begin
            write_step_limit(limit_settings[k]);
            read_step_limit();
            sender_idle_on = k[0];
            receiver_idle_on = k[1];
            add_random_traffic(175);
            wait_until_idle();
            if (k == 2)
            begin
                // Hold off the receiver while requests keep coming, so the input backs up
                sender_idle_on = 1'b0;
                @(negedge clk);
                hold_left = 250;
                add_random_traffic(40);
                wait_until_idle();
            end
        end

        repeat (20) @(posedge clk);
        if (mismatches == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

FILE: files.f
rtl/jits_pkg.sv
rtl/joint_impedance_torque_step_core.sv
rtl/jits_checker.sv
tb/joint_impedance_torque_step_core_tb.sv
